FILE: sv/sacc_pkg.sv
// Shared types and constants of the set-associative cache tag controller.
// No dependencies; sacc_front, sacc_back, the top level and the checker import this package.
`default_nettype none
package sacc_pkg;

   localparam int TAG_W      = 30;
   localparam int ADDR_W     = 32;
   localparam int SET_MAX_W  = 12;
   localparam int WCNT_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETS_LOG2       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LOG2      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_RANDOM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_BACK_MODE = 3'd4;

   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   typedef struct packed {
      logic              command;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic              bypass;
      logic              hit;
      logic [2:0]        way;
      logic              fill_needed;
      logic [ADDR_W-1:0] fill_line_address;
      logic              writeback_needed;
      logic [ADDR_W-1:0] victim_line_address;
      logic              mem_write;
   } rsp_type;

   // One classified access as it travels from the front to the back.
   typedef struct packed {
      logic                 bypass;
      logic                 is_write;
      logic [WCNT_W-1:0]    ways;
      logic [SET_MAX_W-1:0] set;
      logic [TAG_W-1:0]     tag;
      logic [ADDR_W-1:0]    line;
      logic [3:0]           tag_shift;
      logic [2:0]           blk;
   } job_type;

   function automatic logic [15:0] lfsr_next(input logic [15:0] v);
      logic fb;
      fb = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {fb, v[15:1]};
   endfunction

endpackage
`default_nettype wire

FILE: sv/sacc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module sacc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: sv/sacc_fifo.sv
// Two-entry queue of fixed-width words, used between the stages of the block.
// No dependencies.
`default_nettype none
module sacc_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff ^ do_push;
      rptr_in  = rptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

FILE: sv/sacc_front.sv
// Front end: clamps the geometry registers and splits an address into set, tag, line.
// Depends on sacc_pkg.
`default_nettype none
module sacc_front
   import sacc_pkg::*;
#(
   parameter int MAX_WAYS = 8,
   parameter int MAX_SETS = 256
) (
   input  wire req_type   req,
   input  wire logic [3:0] ways_in_use,
   input  wire logic [3:0] sets_log2,
   input  wire logic [2:0] block_log2,
   output job_type        job
);
   localparam int SLOG_MAX = $clog2(MAX_SETS + 1) - 1;

   logic [WCNT_W-1:0] ways;
   logic [3:0]        s;
   logic [2:0]        b;
   logic [ADDR_W-1:0] set_mask, blk_mask, shifted;

   always_comb begin
      ways = ({1'b0, ways_in_use} > WCNT_W'(MAX_WAYS)) ? WCNT_W'(MAX_WAYS)
                                                       : {1'b0, ways_in_use};
      s = (sets_log2 > 4'(SLOG_MAX)) ? 4'(SLOG_MAX) : sets_log2;
      b = (block_log2 < 3'd2) ? 3'd2 : ((block_log2 > 3'd6) ? 3'd6 : block_log2);
      set_mask = (ADDR_W'(1) << s) - ADDR_W'(1);
      blk_mask = (ADDR_W'(1) << b) - ADDR_W'(1);
      shifted  = req.address >> b;
      job.bypass    = ways == '0;
      job.is_write  = req.command;
      job.ways      = ways;
      job.set       = SET_MAX_W'(shifted & set_mask);
      job.tag       = TAG_W'(req.address >> ({1'b0, s} + {2'b0, b}));
      job.line      = req.address & ~blk_mask;
      job.tag_shift = s + {1'b0, b};
      job.blk       = b;
   end
endmodule
`default_nettype wire

FILE: sv/sacc_back.sv
// Back end: clears the tag store, looks up a set, picks the way and writes the set back.
// Depends on sacc_pkg and sacc_ram.
`default_nettype none
module sacc_back
   import sacc_pkg::*;
#(
   parameter int MAX_WAYS   = 8,
   parameter int MAX_SETS   = 256,
   parameter int STAMP_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type job_word,
   input  wire logic    job_empty,
   output logic         job_pop,
   input  wire logic    replace_random,
   input  wire logic    write_back_mode,
   output rsp_type      rsp,
   output logic         rsp_push,
   input  wire logic    rsp_full,
   output logic         clearing
);
   localparam int SET_W = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
   localparam int LVL   = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 0;
   localparam int NP    = 1 << LVL;
   localparam int ROW_W = MAX_WAYS * (TAG_W + 2 + STAMP_BITS);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_RAND  = 3'd3;
   localparam logic [2:0] ST_LRU   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [SET_W-1:0]      clr_ff, clr_in;
   job_type               job_ff, job_in;
   logic [ROW_W-1:0]      row_ff, row_in, rd_data, wr_data;
   logic                  hit_ff, hit_in;
   logic [WAY_W-1:0]      pick_ff, pick_in;
   logic [STAMP_BITS-1:0] cnt_ff, cnt_in;
   logic [15:0]           lfsr_ff, lfsr_in, mod_ff, mod_in;
   logic [4:0]            rem_ff, rem_in;
   logic [1:0]            step_ff, step_in;
   logic [2:0]            lvl_ff, lvl_in;
   logic [STAMP_BITS-1:0] cst_ff [NP];
   logic [STAMP_BITS-1:0] cst_in [NP];
   logic [WAY_W-1:0]      cix_ff [NP];
   logic [WAY_W-1:0]      cix_in [NP];
   logic [NP-1:0]         clv_ff, clv_in;

   logic [MAX_WAYS-1:0][STAMP_BITS-1:0] rd_st, rw_st, wr_st;
   logic [MAX_WAYS-1:0]                 rd_dt, rd_vl, rw_dt, rw_vl, wr_dt, wr_vl;
   logic [MAX_WAYS-1:0][TAG_W-1:0]      rd_tg, rw_tg, wr_tg;

   logic                  we;
   logic [SET_W-1:0]      waddr, raddr;
   logic                  f_hit, f_inv, left_win, wb;
   logic [WAY_W-1:0]      f_hway, f_iway;
   logic [5:0]            t;
   logic [STAMP_BITS-1:0] cnt_next;

   assign {rd_st, rd_dt, rd_vl, rd_tg} = rd_data;
   assign {rw_st, rw_dt, rw_vl, rw_tg} = row_ff;
   assign wr_data  = clearing ? '0 : {wr_st, wr_dt, wr_vl, wr_tg};
   assign clearing = state_ff == ST_CLEAR;
   assign cnt_next = cnt_ff + STAMP_BITS'(1);

   sacc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wr_data),
      .raddr (raddr),
      .rdata (rd_data)
   );

   always_comb begin
      f_hit  = 1'b0;
      f_inv  = 1'b0;
      f_hway = '0;
      f_iway = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (WCNT_W'(w) < job_ff.ways && rd_vl[w] && rd_tg[w] == job_ff.tag) begin
            f_hit  = 1'b1;
            f_hway = WAY_W'(w);
         end
         if (WCNT_W'(w) < job_ff.ways && !rd_vl[w]) begin
            f_inv  = 1'b1;
            f_iway = WAY_W'(w);
         end
      end
   end

   always_comb begin
      wr_st = rw_st;
      wr_dt = rw_dt;
      wr_vl = rw_vl;
      wr_tg = rw_tg;
      wb    = !hit_ff && rw_vl[pick_ff] && rw_dt[pick_ff];
      if (!hit_ff) begin
         wr_vl[pick_ff] = 1'b1;
         wr_tg[pick_ff] = job_ff.tag;
         wr_dt[pick_ff] = 1'b0;
      end
      if (job_ff.is_write) begin
         wr_dt[pick_ff] = write_back_mode;
      end
      if (!replace_random) begin
         wr_st[pick_ff] = cnt_next;
      end
      rsp = '0;
      rsp.bypass = job_ff.bypass;
      if (!job_ff.bypass) begin
         rsp.hit               = hit_ff;
         rsp.way               = 3'(pick_ff);
         rsp.fill_needed       = !hit_ff;
         rsp.fill_line_address = job_ff.line;
         rsp.writeback_needed  = wb;
         rsp.victim_line_address = wb ? ((ADDR_W'(rw_tg[pick_ff]) << job_ff.tag_shift)
                                   | (ADDR_W'(job_ff.set) << job_ff.blk)) : '0;
         rsp.mem_write         = job_ff.is_write && !write_back_mode;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      job_in   = job_ff;
      row_in   = row_ff;
      hit_in   = hit_ff;
      pick_in  = pick_ff;
      cnt_in   = cnt_ff;
      lfsr_in  = lfsr_ff;
      mod_in   = mod_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      lvl_in   = lvl_ff;
      cst_in   = cst_ff;
      cix_in   = cix_ff;
      clv_in   = clv_ff;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      we       = 1'b0;
      waddr    = job_ff.set[SET_W-1:0];
      raddr    = job_word.set[SET_W-1:0];
      t        = '0;
      left_win = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            clr_in = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_word;
               state_in = job_word.bypass ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            row_in = rd_data;
            hit_in = f_hit;
            for (int i = 0; i < NP; i++) begin
               cst_in[i] = (i < MAX_WAYS) ? rd_st[i] : '0;
               cix_in[i] = (i < MAX_WAYS) ? WAY_W'(i) : '0;
               clv_in[i] = (i < MAX_WAYS) && (WCNT_W'(i) < job_ff.ways);
            end
            lvl_in  = '0;
            step_in = '0;
            rem_in  = '0;
            if (f_hit) begin
               pick_in  = f_hway;
               state_in = ST_DONE;
            end else if (f_inv) begin
               pick_in  = f_iway;
               state_in = ST_DONE;
            end else if (replace_random) begin
               lfsr_in  = lfsr_next(lfsr_ff);
               mod_in   = lfsr_next(lfsr_ff);
               state_in = ST_RAND;
            end else if (LVL == 0) begin
               pick_in  = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_LRU;
            end
         end
         ST_RAND: begin
            for (int k = 0; k < 4; k++) begin
               t = {rem_in, mod_in[15]};
               mod_in = {mod_in[14:0], 1'b0};
               if (t >= {1'b0, job_ff.ways}) begin
                  t = t - {1'b0, job_ff.ways};
               end
               rem_in = t[4:0];
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               pick_in  = rem_in[WAY_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_LRU: begin
            for (int i = 0; i < NP / 2; i++) begin
               left_win = clv_ff[2*i] && (!clv_ff[2*i+1] || cst_ff[2*i] <= cst_ff[2*i+1]);
               cst_in[i] = left_win ? cst_ff[2*i] : cst_ff[2*i+1];
               cix_in[i] = left_win ? cix_ff[2*i] : cix_ff[2*i+1];
               clv_in[i] = clv_ff[2*i] || clv_ff[2*i+1];
            end
            lvl_in = lvl_ff + 3'd1;
            if (lvl_ff == 3'(LVL - 1)) begin
               pick_in  = cix_in[0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
               if (!job_ff.bypass) begin
                  we     = 1'b1;
                  cnt_in = cnt_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         lfsr_ff  <= LFSR_SEED;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         lfsr_ff  <= lfsr_in;
      end
      job_ff  <= job_in;
      row_ff  <= row_in;
      hit_ff  <= hit_in;
      pick_ff <= pick_in;
      mod_ff  <= mod_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      lvl_ff  <= lvl_in;
      cst_ff  <= cst_in;
      cix_ff  <= cix_in;
      clv_ff  <= clv_in;
   end
endmodule
`default_nettype wire

FILE: sv/set_assoc_cache_tag_controller_core.sv
// Top level of the set-associative cache tag controller: CSRs, front, queues, back.
// Depends on sacc_pkg, sacc_front, sacc_fifo and sacc_back.
//
// Accesses enter as words on req_word with req_push while req_full is low. Each
// access yields one result word on rsp_word while rsp_empty is low, taken with
// rsp_pop. Results come out in access order.
// The front splits the address and places the access in a two-entry queue; the
// back reads the set's row from the tag RAM, decides, and writes the row back.
// In the back, a hit or a fill into an invalid way goes from read to done, a random
// victim passes the RAND steps and an LRU victim one LRU step per tree level first,
// a bypass skips read. The back finishes one access before it takes the next.
// The queue on the result side holds two words; while it is full the back
// holds its finished access and the front queue fills, then req_full rises.
// After reset the back clears every row of the tag RAM with req_full high. CSR
// writes are always ready and must be made while the block holds no access.
`default_nettype none
module set_assoc_cache_tag_controller_core
   import sacc_pkg::*;
#(
   parameter int MAX_WAYS   = 8,
   parameter int MAX_SETS   = 256,
   parameter int STAMP_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_word,
   input  wire logic                  req_push,
   output logic                       req_full,
   output rsp_type                    rsp_word,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);
   logic [3:0] ways_ff, sets_ff;
   logic [2:0] blk_ff;
   logic       rand_ff, wbm_ff;
   job_type    job_new, job_head;
   logic       job_full, job_empty, job_pop, clearing;
   rsp_type    rsp_new;
   logic       rsp_push, rsp_full;

   assign csr_ready = 1'b1;
   assign req_full  = job_full || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_ff <= 4'd1;
         sets_ff <= 4'd4;
         blk_ff  <= 3'd4;
         rand_ff <= 1'b0;
         wbm_ff  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WAYS_IN_USE:     ways_ff <= csr_data;
            CSR_SETS_LOG2:       sets_ff <= csr_data;
            CSR_BLOCK_LOG2:      blk_ff  <= csr_data[2:0];
            CSR_REPLACE_RANDOM:  rand_ff <= csr_data[0];
            CSR_WRITE_BACK_MODE: wbm_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   sacc_front #(.MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_front (
      .req         (req_word),
      .ways_in_use (ways_ff),
      .sets_log2   (sets_ff),
      .block_log2  (blk_ff),
      .job         (job_new)
   );

   sacc_fifo #(.WIDTH($bits(job_type))) u_job_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push && !clearing),
      .wdata (job_new),
      .full  (job_full),
      .pop   (job_pop),
      .rdata (job_head),
      .empty (job_empty)
   );

   sacc_back #(
      .MAX_WAYS   (MAX_WAYS),
      .MAX_SETS   (MAX_SETS),
      .STAMP_BITS (STAMP_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_word        (job_head),
      .job_empty       (job_empty),
      .job_pop         (job_pop),
      .replace_random  (rand_ff),
      .write_back_mode (wbm_ff),
      .rsp             (rsp_new),
      .rsp_push        (rsp_push),
      .rsp_full        (rsp_full),
      .clearing        (clearing)
   );

   sacc_fifo #(.WIDTH($bits(rsp_type))) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_new),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_word),
      .empty (rsp_empty)
   );
endmodule
`default_nettype wire

FILE: sv/sacc_checker.sv
// Port-level checks of the cache tag controller and their bind to the top level.
// Depends on sacc_pkg and set_assoc_cache_tag_controller_core.
`default_nettype none
module sacc_checker
   import sacc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire rsp_type rsp_word,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop
);
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present right after reset");

   a_bypass_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.bypass) |-> (!rsp_word.hit && !rsp_word.fill_needed
         && !rsp_word.writeback_needed && !rsp_word.mem_write))
      else $error("bypass word carries cache results");

   a_hit_or_fill: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_word.bypass) |-> (rsp_word.hit != rsp_word.fill_needed))
      else $error("word is neither a hit nor a fill");

   a_wb_on_fill: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_word.writeback_needed || rsp_word.victim_line_address != '0))
      |-> (rsp_word.fill_needed && rsp_word.writeback_needed))
      else $error("writeback without a fill");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("stalled result word changed");
endmodule

bind set_assoc_cache_tag_controller_core sacc_checker u_sacc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_word  (rsp_word),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop)
);
`default_nettype wire
